>>> rtl/arbp_pkg.sv
// ----------------------------------------------------------------------------
// Audio ring buffer package
// Shared constants, result codes and the command and status structs that
// join the burst-pop controller to its datapath.
// ----------------------------------------------------------------------------
package arbp_pkg;

   // Ring geometry. The ring always keeps one slot empty.
   localparam int BUFFER_DEPTH = 1024;
   localparam int IDX_W        = $clog2(BUFFER_DEPTH);
   localparam int MAX_BURST    = 64;
   localparam int BURST_W      = 7;
   localparam int DATA_W       = 32;
   localparam int CMP_W        = (IDX_W > BURST_W) ? IDX_W : BURST_W;

   // Configuration space.
   localparam int                CSR_AW        = 3;
   localparam logic [CSR_AW-3:0] REG_SILENCE   = '0;
   localparam logic [DATA_W-1:0] SILENCE_RESET = 32'h00FF_00FF;

   // Request operations.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_STORED  = 2'd0;
   localparam logic [1:0] KIND_SILENCE = 2'd1;
   localparam logic [1:0] KIND_ACCEPT  = 2'd2;
   localparam logic [1:0] KIND_REFUSE  = 2'd3;

   // Source selection for the result register.
   typedef logic [1:0] src_type;
   localparam src_type SRC_STAT = 2'd0;
   localparam src_type SRC_SIL  = 2'd1;
   localparam src_type SRC_MEM  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    capture;   // request taken: latch its parameters
      logic    wr_en;     // store the pushed sample
      logic    rd_en;     // read the ring at the walking pointer
      logic    load;      // load the result register
      src_type src;       // what the result register is loaded from
      logic    adv_rd;    // commit the walking pointer to the read index
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op;           // operation of the request on the port
      logic full;         // ring holds depth minus one words
      logic underrun;     // fewer words stored than the saturated burst
      logic zero;         // saturated burst is zero
      logic out_free;     // result register can take a new result
      logic cnt_last;     // one word of the burst remains
   } sts_type;

endpackage

>>> rtl/audio_ring_buffer_burst_pop.sv
// ----------------------------------------------------------------------------
// Audio ring buffer with burst pop
// A ring of audio words that keeps one slot empty. A push stores one sample
// or is refused when the ring is full; a pop emits a burst of stored words,
// or silence words when too few are stored; a zero burst emits no result.
//
//   Channel   Direction  Handshake          Contents
//   req_      in         valid / ready      op, sample, burst_count
//   rsp_      out        valid / ready      out_word, kind, last
//   csr_      in         APB-style          silence_word at byte address 0
//
// A push stores its sample as it is taken, unless the ring is full, and
// loads its status result in S_STAT once the result register is free. A
// pop of stored words issues the registered memory read in S_RD, then loads
// one word a cycle in S_LOAD while the consumer keeps up; a silence pop loads
// its words in S_SIL. The single memory read port sets the one-word-a-cycle
// pace. A request is accepted only when the previous one has issued all
// results. A stalled consumer holds the result register and pauses the burst.
// Reset is synchronous; the sample memory is not cleared.
// ----------------------------------------------------------------------------
module audio_ring_buffer_burst_pop (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [arbp_pkg::DATA_W-1:0]     req_sample,
   input  logic [arbp_pkg::BURST_W-1:0]    req_burst_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [arbp_pkg::DATA_W-1:0]     rsp_out_word,
   output logic [1:0]                      rsp_kind,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [arbp_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [arbp_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [arbp_pkg::DATA_W-1:0]     csr_prdata,
   output logic                            csr_pready
);
   import arbp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_pready = 1'b1;

   // Sequencer.
   arbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and result path.
   arbp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_sample      (req_sample),
      .req_burst_count (req_burst_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_word    (rsp_out_word),
      .rsp_kind        (rsp_kind),
      .rsp_last        (rsp_last)
   );

   // A push status result carries a zero word and closes its request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_ACCEPT || rsp_kind == KIND_REFUSE))
      |-> (rsp_out_word == '0 && rsp_last))
      else $error("push status result with nonzero word or without last");

   // The result register is never loaded over a result not yet taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> sts.out_free)
      else $error("result register overwritten");

   // The sample memory is written only for a taken push into a non-full ring.
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (req_valid && req_ready && req_op == OP_PUSH && !sts.full))
      else $error("unexpected sample memory write");

   // An underrun pop never reads the sample memory.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_POP && sts.underrun)
      |=> !cmd.rd_en)
      else $error("memory read issued on underrun");

endmodule

>>> rtl/arbp_ctrl.sv
// ----------------------------------------------------------------------------
// Audio ring buffer controller
// State machine that sequences pushes, silence bursts and stored bursts.
// ----------------------------------------------------------------------------
module arbp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  arbp_pkg::sts_type sts,
   output arbp_pkg::cmd_type cmd
);
   import arbp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_STAT = 3'd1;
   localparam logic [2:0] S_SIL  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_LOAD = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.src     = SRC_STAT;
      cmd.capture = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (sts.op == OP_PUSH) begin
                  cmd.wr_en = !sts.full;
                  state_in  = S_STAT;
               end else if (sts.zero) begin
                  state_in = S_IDLE;
               end else if (sts.underrun) begin
                  state_in = S_SIL;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_STAT: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_STAT;
               state_in = S_IDLE;
            end
         end
         S_SIL: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_SIL;
               if (sts.cnt_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            // Each word loaded but the last issues the read of the next one.
            if (sts.out_free) begin
               cmd.load = 1'b1;
               cmd.src  = SRC_MEM;
               if (sts.cnt_last) begin
                  cmd.adv_rd = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  cmd.rd_en = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/arbp_datapath.sv
// ----------------------------------------------------------------------------
// Audio ring buffer datapath
// Sample memory, ring indices, burst counter, silence register and the
// result register.
// ----------------------------------------------------------------------------
module arbp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_op,
   input  logic [arbp_pkg::DATA_W-1:0]           req_sample,
   input  logic [arbp_pkg::BURST_W-1:0]          req_burst_count,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [arbp_pkg::CSR_AW-1:0]           csr_paddr,
   input  logic [arbp_pkg::DATA_W-1:0]           csr_pwdata,
   output logic [arbp_pkg::DATA_W-1:0]           csr_prdata,
   input  arbp_pkg::cmd_type                     cmd,
   output arbp_pkg::sts_type                     sts,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [arbp_pkg::DATA_W-1:0]           rsp_out_word,
   output logic [1:0]                            rsp_kind,
   output logic                                  rsp_last
);
   import arbp_pkg::*;

   logic [DATA_W-1:0]  mem [BUFFER_DEPTH];
   logic [DATA_W-1:0]  mem_q_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [IDX_W-1:0]   wr_idx_ff;
   logic [IDX_W-1:0]   rd_ptr_ff;
   logic [BURST_W-1:0] cnt_ff;
   logic [1:0]         stat_kind_ff;
   logic [DATA_W-1:0]  silence_ff;
   logic               out_valid_ff;
   logic [DATA_W-1:0]  out_word_ff;
   logic [1:0]         out_kind_ff;
   logic               out_last_ff;

   logic [IDX_W-1:0]   held;
   logic [BURST_W-1:0] burst_sat;
   logic               csr_wr;
   logic               out_free;
   logic [DATA_W-1:0]  out_word_in;
   logic [1:0]         out_kind_in;

   // Occupancy and burst size of the request on the port.
   assign held      = wr_idx_ff - rd_idx_ff;
   assign burst_sat = (req_burst_count > BURST_W'(MAX_BURST)) ?
                      BURST_W'(MAX_BURST) : req_burst_count;
   assign out_free  = !out_valid_ff || rsp_ready;

   assign sts.op       = req_op;
   assign sts.full     = (held == IDX_W'(BUFFER_DEPTH - 1));
   assign sts.underrun = (CMP_W'(held) < CMP_W'(burst_sat));
   assign sts.zero     = (burst_sat == '0);
   assign sts.out_free = out_free;
   assign sts.cnt_last = (cnt_ff == BURST_W'(1));

   // Configuration register.
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_AW-1:2] == REG_SILENCE);
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_SILENCE) ? silence_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff <= SILENCE_RESET;
      end else if (csr_wr) begin
         silence_ff <= csr_pwdata;
      end
   end

   // Sample memory with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_idx_ff] <= req_sample;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[rd_ptr_ff];
      end
   end

   // Ring indices, walking read pointer and burst counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (cmd.wr_en) begin
            wr_idx_ff <= wr_idx_ff + IDX_W'(1);
         end
         if (cmd.capture) begin
            rd_ptr_ff <= rd_idx_ff;
            cnt_ff    <= burst_sat;
         end else begin
            if (cmd.rd_en) begin
               rd_ptr_ff <= rd_ptr_ff + IDX_W'(1);
            end
            if (cmd.load && (cmd.src != SRC_STAT)) begin
               cnt_ff <= cnt_ff - BURST_W'(1);
            end
         end
         if (cmd.adv_rd) begin
            rd_idx_ff <= rd_ptr_ff;
         end
      end
   end

   // Push status kind, latched when the request is taken.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         stat_kind_ff <= sts.full ? KIND_REFUSE : KIND_ACCEPT;
      end
   end

   // Result source selection.
   always_comb begin
      case (cmd.src)
         SRC_SIL: begin
            out_word_in = silence_ff;
            out_kind_in = KIND_SILENCE;
         end
         SRC_MEM: begin
            out_word_in = mem_q_ff;
            out_kind_in = KIND_STORED;
         end
         default: begin
            out_word_in = '0;
            out_kind_in = stat_kind_ff;
         end
      endcase
   end

   // Result register: holds one result until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_word_ff <= out_word_in;
         out_kind_ff <= out_kind_in;
         out_last_ff <= (cmd.src == SRC_STAT) || sts.cnt_last;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_word = out_word_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_last     = out_last_ff;

endmodule

>>> tb/tb_audio_ring_buffer_burst_pop.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Audio ring buffer burst-pop testbench
// Drives push and pop requests into the ring buffer and checks every result
// word against a cycle-free model of the ring kept inside this bench. A
// directed plan covers the field extremes, underrun, the oversized and zero
// bursts, a full ring and index wrap-around. Random phases with different
// silence words follow, with random idling on both channels and one long
// consumer stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_audio_ring_buffer_burst_pop;
   import arbp_pkg::*;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int RANDOM_PER_PHASE = 74;
   localparam int REPORT_LIMIT     = 10;

   localparam logic [CSR_AW-1:0] SILENCE_ADDR = {REG_SILENCE, 2'b00};

   // One result word as the block presents it.
   typedef struct packed {
      logic [DATA_W-1:0] word;
      logic [1:0]        kind;
      logic              last;
   } ring_result_type;

   // One row of the directed plan. Rows marked typed carry the word and kind
   // that every result of the row must show.
   typedef struct packed {
      logic              op;
      logic [DATA_W-1:0] sample;
      logic [BURST_W-1:0] burst;
      logic [10:0]       repeats;
      logic              typed;
      logic [DATA_W-1:0] word;
      logic [1:0]        kind;
   } step_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam step_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      // Underrun right after reset, then a zero burst.
      '{OP_POP,  32'h0000_0000, 7'd1,   11'd1,    1'b1, SILENCE_RESET, KIND_SILENCE},
      '{OP_POP,  32'h0000_0000, 7'd0,   11'd1,    1'b0, 32'h0,         KIND_STORED},
      // Sample extremes, then a pop one word too long and an exact pop.
      '{OP_PUSH, 32'h0000_0000, 7'd0,   11'd1,    1'b1, 32'h0,         KIND_ACCEPT},
      '{OP_PUSH, 32'hFFFF_FFFF, 7'd0,   11'd1,    1'b1, 32'h0,         KIND_ACCEPT},
      '{OP_POP,  32'h0000_0000, 7'd3,   11'd1,    1'b1, SILENCE_RESET, KIND_SILENCE},
      '{OP_POP,  32'h0000_0000, 7'd2,   11'd1,    1'b0, 32'h0,         KIND_STORED},
      // Oversized burst on an empty ring saturates to the maximum burst.
      '{OP_POP,  32'h0000_0000, 7'd127, 11'd1,    1'b1, SILENCE_RESET, KIND_SILENCE},
      '{OP_PUSH, 32'h1357_9BDF, 7'd0,   11'd70,   1'b1, 32'h0,         KIND_ACCEPT},
      '{OP_POP,  32'h0000_0000, 7'd127, 11'd1,    1'b0, 32'h0,         KIND_STORED},
      '{OP_POP,  32'h0000_0000, 7'd64,  11'd1,    1'b1, SILENCE_RESET, KIND_SILENCE},
      '{OP_POP,  32'h0000_0000, 7'd65,  11'd1,    1'b1, SILENCE_RESET, KIND_SILENCE},
      '{OP_POP,  32'h0000_0000, 7'd6,   11'd1,    1'b0, 32'h0,         KIND_STORED},
      // Fill the ring to depth minus one; the indices wrap on the way.
      '{OP_PUSH, 32'h8000_0001, 7'd0,   11'd1023, 1'b1, 32'h0,         KIND_ACCEPT},
      '{OP_PUSH, 32'h7FFF_FFFE, 7'd0,   11'd1,    1'b1, 32'h0,         KIND_REFUSE},
      '{OP_POP,  32'h0000_0000, 7'd1,   11'd1,    1'b0, 32'h0,         KIND_STORED},
      '{OP_PUSH, 32'hDEAD_BEEF, 7'd0,   11'd1,    1'b1, 32'h0,         KIND_ACCEPT},
      '{OP_PUSH, 32'hFFFF_FFFF, 7'd0,   11'd2,    1'b1, 32'h0,         KIND_REFUSE},
      // Drain the full ring, with an underrun one word short of the end.
      '{OP_POP,  32'h0000_0000, 7'd64,  11'd15,   1'b0, 32'h0,         KIND_STORED},
      '{OP_POP,  32'h0000_0000, 7'd64,  11'd1,    1'b1, SILENCE_RESET, KIND_SILENCE},
      '{OP_POP,  32'h0000_0000, 7'd63,  11'd1,    1'b0, 32'h0,         KIND_STORED},
      // Unused fields set: burst on a push, sample on a pop.
      '{OP_PUSH, 32'h2468_ACE0, 7'd127, 11'd1,    1'b1, 32'h0,         KIND_ACCEPT},
      '{OP_POP,  32'hFFFF_FFFF, 7'd1,   11'd1,    1'b0, 32'h0,         KIND_STORED}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = OP_PUSH;
   logic [DATA_W-1:0]  req_sample = '0;
   logic [BURST_W-1:0] req_burst_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [DATA_W-1:0]  rsp_out_word;
   logic [1:0]         rsp_kind;
   logic               rsp_last;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]  csr_paddr = '0;
   logic [DATA_W-1:0]  csr_pwdata = '0;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   // Ring model state.
   logic [DATA_W-1:0]  ring_words [BUFFER_DEPTH];
   logic [IDX_W-1:0]   head_idx = '0;
   logic [IDX_W-1:0]   tail_idx = '0;
   logic [DATA_W-1:0]  silence_value = SILENCE_RESET;
   ring_result_type    step_out [MAX_BURST];
   ring_result_type    owed_results [$];

   int  mismatch_count = 0;
   int  req_sent = 0;
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   bit  pressure_on = 1'b0;
   bit  pressure_done = 1'b0;

   audio_ring_buffer_burst_pop u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_sample      (req_sample),
      .req_burst_count (req_burst_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_word    (rsp_out_word),
      .rsp_kind        (rsp_kind),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // Number of words currently held in the model ring.
   function automatic int ring_fill();
      logic [IDX_W-1:0] held;
      held = tail_idx - head_idx;
      return int'(held);
   endfunction

   // Apply one request to the model ring. The results land in step_out and
   // their number is returned.
   function automatic int ring_apply(input logic op, input logic [DATA_W-1:0] smp,
                                     input logic [BURST_W-1:0] cnt);
      int want;
      int held;
      held = ring_fill();
      if (op == OP_PUSH) begin
         if (held >= BUFFER_DEPTH - 1) begin
            step_out[0] = '{'0, KIND_REFUSE, 1'b1};
            return 1;
         end
         ring_words[tail_idx] = smp;
         tail_idx = tail_idx + IDX_W'(1);
         step_out[0] = '{'0, KIND_ACCEPT, 1'b1};
         return 1;
      end
      want = (int'(cnt) > MAX_BURST) ? MAX_BURST : int'(cnt);
      if (want == 0) return 0;
      // Too few words stored: the whole burst is silence and nothing moves.
      if (held < want) begin
         for (int i = 0; i < want; i++)
            step_out[i] = '{silence_value, KIND_SILENCE, i == want - 1};
         return want;
      end
      for (int i = 0; i < want; i++)
         step_out[i] = '{ring_words[head_idx + IDX_W'(i)], KIND_STORED, i == want - 1};
      head_idx = head_idx + IDX_W'(want);
      return want;
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // Offer one request after a random gap and log its expected results once
   // it is taken. Called at a rising edge; returns at the acceptance edge.
   task automatic offer_request(input logic op, input logic [DATA_W-1:0] smp,
                                input logic [BURST_W-1:0] cnt, input logic typed,
                                input logic [DATA_W-1:0] word, input logic [1:0] kind);
      int gap;
      int n;
      ring_result_type res;
      if (req_sent % 16 == 0)
         req_idle_on = ($urandom_range(0, 2) != 0);
      gap = req_idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_sample      <= smp;
      req_burst_count <= cnt;
      do @(posedge clock); while (!req_ready);
      req_sent++;
      n = ring_apply(op, smp, cnt);
      for (int j = 0; j < n; j++) begin
         res = step_out[j];
         if (typed) begin
            res.word = word;
            res.kind = kind;
         end
         owed_results.push_back(res);
      end
   endtask

   // Stop offering, wait for every owed result, then let the block go idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the silence word, then read it back.
   task automatic write_silence(input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SILENCE_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      silence_value = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value)
         note_failure($sformatf("silence readback exp %h got %h", value, csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Compare one accepted result against the oldest owed one.
   task automatic check_result();
      ring_result_type due;
      if (owed_results.size() == 0) begin
         note_failure($sformatf("unexpected result word %h kind %0d last %0b",
                                rsp_out_word, rsp_kind, rsp_last));
         return;
      end
      due = owed_results.pop_front();
      if (rsp_out_word !== due.word || rsp_kind !== due.kind || rsp_last !== due.last)
         note_failure($sformatf("exp word %h kind %0d last %0b, got word %h kind %0d last %0b",
                                due.word, due.kind, due.last,
                                rsp_out_word, rsp_kind, rsp_last));
   endtask

   // Result consumer: random stalls per result, idle-free stretches, and one
   // long hold-off once the pressure phase begins.
   initial begin : result_sink
      int stall;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 16 == 0)
            rsp_idle_on = ($urandom_range(0, 2) != 0);
         stall = rsp_idle_on ? $urandom_range(0, 4) : 0;
         if (pressure_on && !pressure_done) begin
            stall = LONG_HOLD_CYCLES;
            pressure_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_result();
         taken++;
      end
   end

   // Watchdog on cycles in which no request, result or register access moves.
   initial begin : stall_watch
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("audio_ring_buffer_burst_pop verification failed");
      $finish;
   end

   // Main sequence: reset, directed plan, then random phases.
   initial begin : stimulus
      step_row_type row;
      logic op;
      logic [DATA_W-1:0] smp;
      logic [BURST_W-1:0] cnt;
      int sel;
      int held;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         for (int k = 0; k < int'(row.repeats); k++)
            offer_request(row.op, row.sample + DATA_W'(k), row.burst,
                          row.typed, row.word, row.kind);
      end
      settle();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               write_silence(32'h0000_0000);
            end
            1: begin
               write_silence(32'hFFFF_FFFF);
               pressure_on = 1'b1;
            end
            default: begin
               write_silence($urandom());
            end
         endcase
         // Slightly more pushes than pops; pops mostly sized to what the ring holds, with some noise bursts.
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            held = ring_fill();
            sel  = $urandom_range(0, 99);
            smp  = $urandom();
            cnt  = BURST_W'($urandom_range(1, MAX_BURST));
            op   = OP_POP;
            if (sel < 52) begin
               op = OP_PUSH;
            end else if (sel < 88 && held > 0) begin
               cnt = BURST_W'($urandom_range(1, (held < MAX_BURST) ? held : MAX_BURST));
            end else if (sel >= 94) begin
               cnt = BURST_W'($urandom_range(0, 127));
            end
            offer_request(op, smp, cnt, 1'b0, '0, KIND_STORED);
         end
         settle();
      end

      if (mismatch_count == 0)
         $display("audio_ring_buffer_burst_pop verification clean");
      else
         $display("audio_ring_buffer_burst_pop verification failed");
      $finish;
   end

endmodule
